### sv/wfgd_pkg.sv
// Shared constants and types for the wait-for graph deadlock detector.
`timescale 1ns / 1ps
`default_nettype none
package wfgd_pkg;

    localparam int TRANSACTIONS = 16;
    localparam int IDX_W        = (TRANSACTIONS > 1) ? $clog2(TRANSACTIONS) : 1;
    localparam int FIELD_W      = 4;

    localparam logic MODE_CLEAR  = 1'b0;
    localparam logic MODE_RECORD = 1'b1;

    typedef struct packed {
        logic             wr;
        logic             set;
        logic [IDX_W-1:0] nxt;
        logic             start;
        logic             step;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

endpackage
`default_nettype wire

### sv/wfgd_req_if.sv
// Update channel: mode, waiter and holder with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface wfgd_req_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [wfgd_pkg::FIELD_W-1:0] waiter;
    logic [wfgd_pkg::FIELD_W-1:0] holder;

    modport source (output valid, output mode, output waiter, output holder, input ready);
    modport sink   (input valid, input mode, input waiter, input holder, output ready);
endinterface
`default_nettype wire

### sv/wfgd_rsp_if.sv
// Result channel: deadlock flag with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface wfgd_rsp_if;
    logic valid;
    logic ready;
    logic deadlock;

    modport source (output valid, output deadlock, input ready);
    modport sink   (input valid, input deadlock, output ready);
endinterface
`default_nettype wire

### sv/wfgd_cell.sv
// One wait-table entry with its live-chain flag.
`timescale 1ns / 1ps
`default_nettype none
module wfgd_cell (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire wfgd_pkg::cell_ctl_t                  ctl,
    input  wire logic [wfgd_pkg::TRANSACTIONS-1:0]    alive_vec,
    output logic                                      alive
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [wfgd_pkg::IDX_W-1:0] next_reg;
    logic [wfgd_pkg::IDX_W-1:0] next_next;
    logic                       alive_reg;
    logic                       alive_next;

    always_comb
    begin
        valid_next = valid_reg;
        next_next  = next_reg;
        alive_next = alive_reg;
        if (ctl.wr)
        begin
            valid_next = ctl.set;
            next_next  = ctl.nxt;
        end
        // alive after k steps: the node and its next k-1 successors are all waiting
        if (ctl.start)
        begin
            alive_next = 1'b1;
        end
        else if (ctl.step)
        begin
            alive_next = valid_reg && alive_vec[next_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            alive_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            alive_reg <= alive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        next_reg <= next_next;
    end

    assign alive = alive_reg;

endmodule
`default_nettype wire

### sv/wait_for_graph_deadlock_detect_top.sv
// Top level: wait-for table as a row of cells, cycle check by chain propagation.
//
//  channel | dir | fields                  | word accepted when
//  req     | in  | mode, waiter, holder    | req.valid && req.ready
//  rsp     | out | deadlock                | rsp.valid && rsp.ready
//
// An update is written into its cell on the accepting edge; then every cell
// takes TRANSACTIONS steps of alive = valid && alive[successor], and the OR
// of the flags is the result; no new update is taken until it is registered.
// Reset clears every entry to not waiting. A waiting result in the output
// register does not block the next update; the result of that one holds
// until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module wait_for_graph_deadlock_detect_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    wfgd_req_if.sink   req,
    wfgd_rsp_if.source rsp
);

    wfgd_pkg::state_t                   state_reg;
    wfgd_pkg::state_t                   state_next;
    logic [wfgd_pkg::IDX_W-1:0]         cnt_reg;
    logic [wfgd_pkg::IDX_W-1:0]         cnt_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic                               out_dead_reg;
    logic                               out_dead_next;
    logic [wfgd_pkg::TRANSACTIONS-1:0]  alive_vec;
    logic                               accept;
    logic                               waiter_ok;
    logic                               holder_ok;
    logic                               upd_ok;

    assign req.ready = (state_reg == wfgd_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign waiter_ok = int'(req.waiter) < wfgd_pkg::TRANSACTIONS;
    assign holder_ok = int'(req.holder) < wfgd_pkg::TRANSACTIONS;
    assign upd_ok    = accept && waiter_ok
                       && ((req.mode == wfgd_pkg::MODE_CLEAR) || holder_ok);

    genvar gi;
    generate
        for (gi = 0; gi < wfgd_pkg::TRANSACTIONS; gi++)
        begin : g_cell
            wfgd_pkg::cell_ctl_t ctl;

            always_comb
            begin
                ctl.wr    = upd_ok && (int'(req.waiter) == gi);
                ctl.set   = (req.mode == wfgd_pkg::MODE_RECORD);
                ctl.nxt   = wfgd_pkg::IDX_W'(req.holder);
                ctl.start = accept;
                ctl.step  = (state_reg == wfgd_pkg::ST_RUN);
            end

            wfgd_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .alive_vec (alive_vec),
                .alive     (alive_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_dead_next  = out_dead_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            wfgd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next   = '0;
                    state_next = wfgd_pkg::ST_RUN;
                end
            end
            wfgd_pkg::ST_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == wfgd_pkg::IDX_W'(wfgd_pkg::TRANSACTIONS - 1))
                begin
                    state_next = wfgd_pkg::ST_FLUSH;
                end
            end
            wfgd_pkg::ST_FLUSH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_dead_next  = |alive_vec;
                    state_next     = wfgd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wfgd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wfgd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        out_dead_reg <= out_dead_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.deadlock = out_dead_reg;

endmodule
`default_nettype wire

### dv/wait_for_graph_deadlock_detect_top_test.sv
// Self-checking testbench for the wait-for graph deadlock detector top level.
`timescale 1ns / 1ps
`default_nettype none
module wait_for_graph_deadlock_detect_top_test;
    import wfgd_pkg::*;

    localparam int RANDOM_UPDATES = 850;
    localparam int FLAT_UPDATES   = 400;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int DRAIN_CYCLES   = 2 * TRANSACTIONS + 8;
    localparam int MAX_REPORTS    = 10;
    localparam int FIELD_MAX      = (1 << FIELD_W) - 1;

    logic clk = 1'b0;
    logic rst_n;

    wfgd_req_if req_bus ();
    wfgd_rsp_if rsp_bus ();

    wait_for_graph_deadlock_detect_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Predicted wait-for graph and the deadlock flags still owed by the block
    logic             waits_valid [TRANSACTIONS];
    logic [IDX_W-1:0] waits_on    [TRANSACTIONS];
    logic             expected_deadlock_q [$];

    int updates_sent   = 0;
    int results_seen   = 0;
    int deadlocks_seen = 0;
    int failures       = 0;
    int cycle_count    = 0;

    int burst_left   = 0;
    bit gaps_enabled = 1'b1;

    logic [15:0] stall_pattern = '1;
    int          pattern_age   = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void note_failure(string what);
        failures++;
        if (failures <= MAX_REPORTS)
        begin
            $display("ERROR cycle %0d: %s", cycle_count, what);
        end
    endfunction

    // A node lies on a cycle if its chain comes back to it within the table size
    function automatic logic graph_has_cycle();
        int node;
        for (int n = 0; n < TRANSACTIONS; n++)
        begin
            if (waits_valid[n])
            begin
                node = int'(waits_on[n]);
                for (int s = 0; s < TRANSACTIONS; s++)
                begin
                    if (node == n)
                    begin
                        return 1'b1;
                    end
                    if (!waits_valid[node])
                    begin
                        break;
                    end
                    node = int'(waits_on[node]);
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic logic predict_deadlock(logic mode, logic [FIELD_W-1:0] waiter,
                                              logic [FIELD_W-1:0] holder);
        int w;
        int h;
        w = int'(waiter);
        h = int'(holder);
        // an out-of-range waiter, or an out-of-range holder on a record, leaves the graph as it is
        if (w < TRANSACTIONS)
        begin
            if (mode == MODE_CLEAR)
            begin
                waits_valid[w] = 1'b0;
                waits_on[w]    = '0;
            end
            else if (h < TRANSACTIONS)
            begin
                waits_valid[w] = 1'b1;
                waits_on[w]    = IDX_W'(h);
            end
        end
        return graph_has_cycle();
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_update(input logic mode, input logic [FIELD_W-1:0] waiter,
                               input logic [FIELD_W-1:0] holder);
        if (burst_left == 0)
        begin
            if (gaps_enabled)
            begin
                req_bus.valid = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        req_bus.valid  = 1'b1;
        req_bus.mode   = mode;
        req_bus.waiter = waiter;
        req_bus.holder = holder;
        @(posedge clk);
        while (!req_bus.ready)
        begin
            @(posedge clk);
        end
        expected_deadlock_q.push_back(predict_deadlock(mode, waiter, holder));
        updates_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_random_noise();
        send_update($urandom_range(0, 1) ? MODE_RECORD : MODE_CLEAR,
                    FIELD_W'($urandom_range(0, FIELD_MAX)),
                    FIELD_W'($urandom_range(0, FIELD_MAX)));
    endtask

    task automatic clear_all_waits();
        int first;
        int n;
        first = $urandom_range(0, TRANSACTIONS - 1);
        for (int i = 0; i < TRANSACTIONS; i++)
        begin
            n = (first + i) % TRANSACTIONS;
            if (waits_valid[n])
            begin
                send_update(MODE_CLEAR, FIELD_W'(n), FIELD_W'($urandom_range(0, FIELD_MAX)));
            end
        end
    endtask

    // Clear on an empty graph, self-wait, replacement of a wait, two-node cycle
    task automatic test_edge_updates();
        send_update(MODE_CLEAR, '0, FIELD_W'(FIELD_MAX));
        send_update(MODE_RECORD, FIELD_W'(FIELD_MAX), FIELD_W'(FIELD_MAX));
        send_update(MODE_RECORD, FIELD_W'(FIELD_MAX), '0);
        send_update(MODE_RECORD, '0, FIELD_W'(FIELD_MAX));
        send_update(MODE_CLEAR, FIELD_W'(FIELD_MAX), '0);
        send_update(MODE_CLEAR, '0, '0);
    endtask

    // Ring through every transaction, closed by the last word, then cut short
    task automatic test_full_ring();
        for (int n = 0; n < TRANSACTIONS; n++)
        begin
            send_update(MODE_RECORD, FIELD_W'(n), FIELD_W'((n + 1) % TRANSACTIONS));
        end
        send_update(MODE_RECORD, FIELD_W'(7), FIELD_W'(7));
    endtask

    task automatic test_random_updates(input int count);
        int record_pct;
        record_pct = 50;
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
            begin
                record_pct   = 25 * $urandom_range(1, 3);
                gaps_enabled = ($urandom_range(0, 3) != 0);
            end
            send_update(($urandom_range(1, 100) <= record_pct) ? MODE_RECORD : MODE_CLEAR,
                        FIELD_W'($urandom_range(0, FIELD_MAX)),
                        FIELD_W'($urandom_range(0, FIELD_MAX)));
        end
    endtask

    // Build a ring over shuffled nodes, hang tails on it, break it, tidy up
    task automatic test_ring_sequences(input int stop_at);
        int order [TRANSACTIONS];
        int ring_len;
        int j;
        int tmp;
        int victim;
        while (updates_sent < stop_at)
        begin
            gaps_enabled = ($urandom_range(0, 4) != 0);
            for (int i = 0; i < TRANSACTIONS; i++)
            begin
                order[i] = i;
            end
            for (int i = TRANSACTIONS - 1; i > 0; i--)
            begin
                j        = $urandom_range(0, i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            ring_len = ($urandom_range(0, 7) == 0) ? TRANSACTIONS : $urandom_range(1, 6);
            for (int i = 0; i < ring_len; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_random_noise();
                end
                send_update(MODE_RECORD, FIELD_W'(order[i]), FIELD_W'(order[(i + 1) % ring_len]));
            end
            for (int i = ring_len; i < TRANSACTIONS && i < ring_len + 3; i++)
            begin
                if ($urandom_range(0, 1))
                begin
                    send_update(MODE_RECORD, FIELD_W'(order[i]),
                                FIELD_W'(order[$urandom_range(0, ring_len - 1)]));
                end
            end
            victim = order[$urandom_range(0, ring_len - 1)];
            if (ring_len < TRANSACTIONS && $urandom_range(0, 1))
            begin
                send_update(MODE_RECORD, FIELD_W'(victim),
                            FIELD_W'(order[$urandom_range(ring_len, TRANSACTIONS - 1)]));
            end
            else
            begin
                send_update(MODE_CLEAR, FIELD_W'(victim), FIELD_W'($urandom_range(0, FIELD_MAX)));
            end
            clear_all_waits();
        end
    endtask

    // Receiver stalls follow a rotating pattern, reloaded now and then
    always @(negedge clk)
    begin
        if (pattern_age == 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                stall_pattern = '1;
            end
            else
            begin
                stall_pattern = 16'($urandom) | 16'h0001;
            end
            pattern_age = $urandom_range(32, 160);
        end
        rsp_bus.ready = stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        pattern_age--;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            results_seen++;
            if (rsp_bus.deadlock === 1'b1)
            begin
                deadlocks_seen++;
            end
            if (expected_deadlock_q.size() == 0)
            begin
                note_failure($sformatf("unexpected result word, deadlock %0b", rsp_bus.deadlock));
            end
            else if (rsp_bus.deadlock !== expected_deadlock_q[0])
            begin
                note_failure($sformatf("deadlock expected %0b, got %0b",
                                       expected_deadlock_q[0], rsp_bus.deadlock));
                void'(expected_deadlock_q.pop_front());
            end
            else
            begin
                void'(expected_deadlock_q.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles, %0d results outstanding",
                     cycle_count, expected_deadlock_q.size());
            $display("wait_for_graph_deadlock_detect_top test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        req_bus.valid  = 1'b0;
        req_bus.mode   = MODE_CLEAR;
        req_bus.waiter = '0;
        req_bus.holder = '0;
        for (int n = 0; n < TRANSACTIONS; n++)
        begin
            waits_valid[n] = 1'b0;
            waits_on[n]    = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_edge_updates();
        test_full_ring();
        test_random_updates(FLAT_UPDATES);
        test_ring_sequences(updates_sent + RANDOM_UPDATES - FLAT_UPDATES);

        req_bus.valid = 1'b0;
        while (expected_deadlock_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d wait-for updates (flat random and ring build/break sequences).",
                 updates_sent);
        $display("Checked %0d result words, %0d of them flagging a deadlock; %0d failures.",
                 results_seen, deadlocks_seen, failures);
        if (failures == 0 && expected_deadlock_q.size() == 0)
        begin
            $display("wait_for_graph_deadlock_detect_top test passed");
        end
        else
        begin
            $display("wait_for_graph_deadlock_detect_top test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
sv/wfgd_pkg.sv
sv/wfgd_req_if.sv
sv/wfgd_rsp_if.sv
sv/wfgd_cell.sv
sv/wait_for_graph_deadlock_detect_top.sv
dv/wait_for_graph_deadlock_detect_top_test.sv
